/* rtl/core/kts_pkg.sv */
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types, codes and constants of the keyframe track sampler.
// ----------------------------------------------------------------------------
package kts_pkg;

  // Number of scan lanes and the index bits that pick one of them.
  localparam int LANES            = 4;
  localparam int LANE_BITS        = 2;
  localparam int DEFAULT_MAX_KEYS = 64;

  // Shared divider geometry: a 48-bit dividend over a 33-bit divisor,
  // with a quotient known to stay below 2^17.
  localparam int DIVIDEND_W = 48;
  localparam int DIVISOR_W  = 33;
  localparam int QUOT_W     = 17;

  // Item operation codes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Value kinds and interpolation modes.
  localparam logic KIND_VECTOR = 1'b0;
  localparam logic KIND_QUAT   = 1'b1;
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_STEP   = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_VALUE_KIND  = 3'd0,
    CFG_INTERP_MODE = 3'd1,
    CFG_KEY_COUNT   = 3'd2,
    CFG_FALLBACK_C0 = 3'd3,
    CFG_FALLBACK_C1 = 3'd4,
    CFG_FALLBACK_C2 = 3'd5,
    CFG_FALLBACK_C3 = 3'd6
  } cfg_idx_t;

  // What one lane reports about its pair of stamps.
  typedef struct packed {
    logic hit;    // query lies in [ta, tb) of a valid pair
    logic first;  // this lane holds key 0
    logic last;   // this lane holds the last key
  } lane_res_t;

endpackage

/* rtl/core/kts_if.sv */
// ----------------------------------------------------------------------------
// kts_if
// Valid/ready channels of the keyframe track sampler: input and result items.
// ----------------------------------------------------------------------------
interface kts_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic        [5:0]  key_index;
  logic        [31:0] key_stamp;
  logic        [31:0] query_time;
  logic signed [31:0] in_c0;
  logic signed [31:0] in_c1;
  logic signed [31:0] in_c2;
  logic signed [31:0] in_c3;

  modport source (output valid, op, key_index, key_stamp, query_time,
                  in_c0, in_c1, in_c2, in_c3, input ready);
  modport sink   (input valid, op, key_index, key_stamp, query_time,
                  in_c0, in_c1, in_c2, in_c3, output ready);
endinterface

interface kts_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_c0;
  logic signed [31:0] out_c1;
  logic signed [31:0] out_c2;
  logic signed [31:0] out_c3;
  logic               interior;
  logic               used_fallback;

  modport source (output valid, out_c0, out_c1, out_c2, out_c3, interior,
                  used_fallback, input ready);
  modport sink   (input valid, out_c0, out_c1, out_c2, out_c3, interior,
                  used_fallback, output ready);
endinterface

/* rtl/core/kts_ram.sv */
// ----------------------------------------------------------------------------
// kts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kts_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/kts_lane.sv */
// ----------------------------------------------------------------------------
// kts_lane
// One scan lane: tests the query time against the pair ending at its key.
// ----------------------------------------------------------------------------
module kts_lane #(
  parameter int KIDX_W = 4,
  parameter int NW     = 7
) (
  input  logic [31:0]       query,
  input  logic [31:0]       ta,
  input  logic [31:0]       tb,
  input  logic [KIDX_W-1:0] k,
  input  logic [NW-1:0]     n,
  output kts_pkg::lane_res_t res
);
  import kts_pkg::*;

  // The pair (k-1, k) exists only for 1 <= k <= n-1.
  always_comb begin
    res.hit   = (k != '0) && (k < n) && (query >= ta) && (query < tb);
    res.first = (k == '0);
    res.last  = (({1'b0, k} + 1'b1) == n);
  end

endmodule

/* rtl/core/kts_merge.sv */
// ----------------------------------------------------------------------------
// kts_merge
// Combines the lane results of each scan step: keeps the first bracketing
// pair, the stamps of the first and last keys, and the stamp carried over
// to lane 0 of the next step.
// ----------------------------------------------------------------------------
module kts_merge #(
  parameter int SW     = 4,
  parameter int KIDX_W = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  logic                               dvalid,
  input  logic [SW-1:0]                      step,
  input  kts_pkg::lane_res_t [kts_pkg::LANES-1:0] res,
  input  logic [kts_pkg::LANES-1:0][31:0]    ta,
  input  logic [kts_pkg::LANES-1:0][31:0]    tb,
  output logic                               found,
  output logic [KIDX_W-1:0]                  pair_k,
  output logic [31:0]                        pair_ta,
  output logic [31:0]                        pair_tb,
  output logic [31:0]                        first_stamp,
  output logic [31:0]                        last_stamp,
  output logic [31:0]                        carry
);
  import kts_pkg::*;

  logic                 any_hit;
  logic [LANE_BITS-1:0] sel;

  // Priority pick: the lowest lane with a hit holds the earliest pair.
  always_comb begin
    any_hit = 1'b0;
    sel     = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (res[l].hit) begin
        any_hit = 1'b1;
        sel     = LANE_BITS'(l);
      end
    end
  end

  // Found flag is control state.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= 1'b0;
    end else if (dvalid && !found && any_hit) begin
      found <= 1'b1;
    end
  end

  // Captured stamps and pair index.
  always_ff @(posedge clk) begin
    if (dvalid) begin
      if (!found && any_hit) begin
        pair_k  <= KIDX_W'({step, sel});
        pair_ta <= ta[sel];
        pair_tb <= tb[sel];
      end
      if (res[0].first) begin
        first_stamp <= tb[0];
      end
      for (int l = 0; l < LANES; l++) begin
        if (res[l].last) begin
          last_stamp <= tb[l];
        end
      end
      carry <= tb[LANES-1];
    end
  end

endmodule

/* rtl/core/kts_div.sv */
// ----------------------------------------------------------------------------
// kts_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QUOT_W bits.
// ----------------------------------------------------------------------------
module kts_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [kts_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [kts_pkg::DIVISOR_W-1:0]   divisor,
  output logic                            done,
  output logic [kts_pkg::QUOT_W-1:0]      quot
);
  import kts_pkg::*;

  localparam int CW = $clog2(QUOT_W + 1);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [DIVISOR_W:0]   rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem[DIVISOR_W-1:0], quot[QUOT_W-1]};
    fits  = (trial >= {1'b0, dsr});
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= (DIVISOR_W + 1)'(dividend[DIVIDEND_W-1:QUOT_W]);
      quot <= dividend[QUOT_W-1:0];
      dsr  <= divisor;
    end else if (busy) begin
      rem  <= fits ? (trial - {1'b0, dsr}) : trial;
      quot <= {quot[QUOT_W-2:0], fits};
    end
  end

endmodule

/* rtl/core/keyframe_track_sampler_core.sv */
// ----------------------------------------------------------------------------
// keyframe_track_sampler_core
// Keyframe table with clamped step or linear sampling of vectors and
// normalised quaternions.
// ----------------------------------------------------------------------------
// Usage:
//   item_in carries load and sample items; item_out carries one result item
//   per sample. Loads write one key into the table and give no result.
//   Configuration is written through cfg_we / cfg_index / cfg_data while idle.
// Sequence (from the accepting cycle up to the loaded result):
//   A load item is written into the tables as it is accepted. A sample item
//   first scans the stamps with four lanes, one bank read per lane per cycle.
//   A clamped or step result then reads its key and finishes. A linear result
//   first works out the fraction (shared divider, one bit a cycle), then
//   reads both keys, runs the lerp (one multiplier) and finishes. A quaternion
//   adds the squares, the square root (one bit a cycle) and four normalising
//   divisions. An empty table goes straight to the finishing state with the
//   fallback.
//   The next item is taken in the cycle after the result is loaded.
// Reset:
//   Registers return to their reset values; table contents are undefined
//   until loaded. No clearing pass is needed.
// Stall:
//   The result waits in an output register; the next item is taken
//   meanwhile, and a new result waits until the old one has gone.
// ----------------------------------------------------------------------------
module keyframe_track_sampler_core #(
  parameter int MAX_KEYS = kts_pkg::DEFAULT_MAX_KEYS
) (
  input  logic        clk,
  input  logic        rst,
  kts_in_if.sink      item_in,
  kts_out_if.source   item_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import kts_pkg::*;

  localparam int KW         = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NW         = $clog2(MAX_KEYS + 1);
  localparam int BANK_DEPTH = (MAX_KEYS + LANES - 1) / LANES;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int KIDX_W     = BAW + LANE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_END, S_DECIDE, S_FRAC, S_RD_A, S_RD_B, S_LD_B,
    S_LERP, S_SQ, S_ROOT_INIT, S_SQRT, S_NORM_GO, S_NORM_WAIT, S_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic               value_kind;
  logic               interp_mode;
  logic [6:0]         key_count;
  logic signed [31:0] fallback [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      value_kind  <= KIND_VECTOR;
      interp_mode <= MODE_LINEAR;
      key_count   <= '0;
      fallback[0] <= '0;
      fallback[1] <= '0;
      fallback[2] <= '0;
      fallback[3] <= 32'sd65536;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VALUE_KIND:  value_kind  <= cfg_data[0];
        CFG_INTERP_MODE: interp_mode <= cfg_data[0];
        CFG_KEY_COUNT:   key_count   <= cfg_data[6:0];
        CFG_FALLBACK_C0: fallback[0] <= cfg_data;
        CFG_FALLBACK_C1: fallback[1] <= cfg_data;
        CFG_FALLBACK_C2: fallback[2] <= cfg_data;
        CFG_FALLBACK_C3: fallback[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective key count, saturated at the table size.
  logic [NW-1:0] n;
  assign n = (key_count > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(key_count);

  logic in_take, take_load, take_sample, slot_ok;
  assign item_in.ready = (state == S_IDLE);
  assign in_take       = item_in.valid && item_in.ready;
  assign slot_ok       = (item_in.key_index < MAX_KEYS);
  assign take_load     = in_take && (item_in.op == OP_LOAD) && slot_ok;
  assign take_sample   = in_take && (item_in.op == OP_SAMPLE);

  // Stamp banks: key k lives in bank k mod LANES at row k / LANES.
  logic [BAW-1:0]             step, last_step, step_d;
  logic                       scan_dv;
  logic [LANES-1:0][31:0]     stamp_rd;
  logic [LANES-1:0][31:0]     lane_ta;
  lane_res_t [LANES-1:0]      lane_res;
  logic [31:0]                carry;
  logic [31:0]                query;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    kts_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_stamp (
      .clk   (clk),
      .we    (take_load && (item_in.key_index[LANE_BITS-1:0] == LANE_BITS'(l))),
      .waddr (BAW'(item_in.key_index >> LANE_BITS)),
      .wdata (item_in.key_stamp),
      .raddr (step),
      .rdata (stamp_rd[l])
    );

    if (l == 0) begin : g_first
      assign lane_ta[l] = carry;
    end else begin : g_rest
      assign lane_ta[l] = stamp_rd[l-1];
    end

    kts_lane #(.KIDX_W(KIDX_W), .NW(NW)) u_lane (
      .query (query),
      .ta    (lane_ta[l]),
      .tb    (stamp_rd[l]),
      .k     ({step_d, LANE_BITS'(l)}),
      .n     (n),
      .res   (lane_res[l])
    );
  end

  logic              found;
  logic [KIDX_W-1:0] pair_k;
  logic [31:0]       pair_ta, pair_tb, first_stamp, last_stamp;

  kts_merge #(.SW(BAW), .KIDX_W(KIDX_W)) u_merge (
    .clk         (clk),
    .rst         (rst),
    .clear       (take_sample),
    .dvalid      (scan_dv),
    .step        (step_d),
    .res         (lane_res & {LANES{{3{scan_dv}}}}),
    .ta          (lane_ta),
    .tb          (stamp_rd),
    .found       (found),
    .pair_k      (pair_k),
    .pair_ta     (pair_ta),
    .pair_tb     (pair_tb),
    .first_stamp (first_stamp),
    .last_stamp  (last_stamp),
    .carry       (carry)
  );

  // Key value table, all four components in one row.
  logic [KW-1:0]  i0, i1, key_raddr;
  logic [127:0]   key_rd;
  assign key_raddr = (state == S_RD_B) ? i1 : i0;

  kts_ram #(.WIDTH(128), .DEPTH(MAX_KEYS)) u_keys (
    .clk   (clk),
    .we    (take_load),
    .waddr (KW'(item_in.key_index)),
    .wdata ({item_in.in_c3, item_in.in_c2, item_in.in_c1, item_in.in_c0}),
    .raddr (key_raddr),
    .rdata (key_rd)
  );

  // Decision after the scan.
  logic clamp_lo, in_span;
  assign clamp_lo = (query <= first_stamp);
  assign in_span  = !clamp_lo && (query < last_stamp) && found;

  // Working registers.
  logic signed [31:0] a_vec [4];
  logic signed [31:0] b_vec [4];
  logic signed [31:0] r_vec [4];
  logic [15:0]        frac;
  logic [1:0]         j;
  logic               interior, used;
  logic [64:0]        sq_sum;
  logic [63:0]        s_rem, root, sbit;
  logic [32:0]        len;

  // Lerp of component j: a + floor((b - a) * u / 2^16).
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic signed [49:0] lerp_full;
  assign diff      = 33'(b_vec[j]) - 33'(a_vec[j]);
  assign prod      = 50'(diff) * 50'($signed({1'b0, frac}));
  assign lerp_full = 50'(a_vec[j]) + (prod >>> 16);

  // Magnitude and square of component j.
  logic [31:0] mag;
  logic [63:0] sq;
  assign mag = r_vec[j][31] ? 32'(-r_vec[j]) : 32'(r_vec[j]);
  assign sq  = 64'(mag) * 64'(mag);

  // One square-root step.
  logic [64:0] root_try;
  logic        root_fits;
  logic [32:0] len_next;
  assign root_try  = 65'(root) + 65'(sbit);
  assign root_fits = (65'(s_rem) >= root_try);
  assign len_next  = sq_sum[64] ? 33'h1_0000_0000 : root[32:0];

  // Shared divider: fraction first, then the normalising divisions.
  logic                  div_start, div_done;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [QUOT_W-1:0]     div_quot;
  logic                  want_lerp;

  assign want_lerp = in_span && (interp_mode == MODE_LINEAR);
  assign div_start = ((state == S_DECIDE) && want_lerp) || (state == S_NORM_GO);

  always_comb begin
    if (state == S_NORM_GO) begin
      div_dividend = {mag, 16'h0};
      div_divisor  = len;
    end else begin
      div_dividend = {query - pair_ta, 16'h0};
      div_divisor  = {1'b0, pair_tb - pair_ta};
    end
  end

  kts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Result register.
  logic               res_valid;
  logic signed [31:0] res_c [4];
  logic               res_interior, res_used;
  logic               res_free;
  assign res_free = !res_valid || item_out.ready;

  assign item_out.valid         = res_valid;
  assign item_out.out_c0        = res_c[0];
  assign item_out.out_c1        = res_c[1];
  assign item_out.out_c2        = res_c[2];
  assign item_out.out_c3        = res_c[3];
  assign item_out.interior      = res_interior;
  assign item_out.used_fallback = res_used;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_dv   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      scan_dv <= (state == S_SCAN);
      step_d  <= step;
      if ((state == S_FINISH) && res_free) begin
        res_valid <= 1'b1;
      end else if (item_out.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take_sample) begin
            query    <= item_in.query_time;
            interior <= 1'b0;
            used     <= (n == '0);
            if (n == '0) begin
              for (int c = 0; c < 4; c++) begin
                r_vec[c] <= fallback[c];
              end
              state <= S_FINISH;
            end else begin
              step      <= '0;
              last_step <= BAW'((n - 1'b1) >> LANE_BITS);
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (step == last_step) begin
            state <= S_SCAN_END;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SCAN_END: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          interior <= in_span;
          if (clamp_lo) begin
            i0 <= '0;
          end else if (in_span) begin
            i0 <= KW'(pair_k - 1'b1);
          end else begin
            i0 <= KW'(n - 1'b1);
          end
          i1    <= KW'(pair_k);
          state <= want_lerp ? S_FRAC : S_RD_A;
        end
        S_FRAC: begin
          if (div_done) begin
            frac  <= div_quot[15:0];
            state <= S_RD_A;
          end
        end
        S_RD_A: begin
          state <= S_RD_B;
        end
        S_RD_B: begin
          for (int c = 0; c < 4; c++) begin
            a_vec[c] <= key_rd[32*c +: 32];
            r_vec[c] <= key_rd[32*c +: 32];
          end
          state <= (interior && interp_mode == MODE_LINEAR) ? S_LD_B : S_FINISH;
        end
        S_LD_B: begin
          for (int c = 0; c < 4; c++) begin
            b_vec[c] <= key_rd[32*c +: 32];
          end
          j     <= '0;
          state <= S_LERP;
        end
        S_LERP: begin
          r_vec[j] <= lerp_full[31:0];
          j        <= j + 1'b1;
          if (j == 2'd3) begin
            sq_sum <= '0;
            state  <= (value_kind == KIND_QUAT) ? S_SQ : S_FINISH;
          end
        end
        S_SQ: begin
          sq_sum <= sq_sum + 65'(sq);
          j      <= j + 1'b1;
          if (j == 2'd3) begin
            state <= S_ROOT_INIT;
          end
        end
        S_ROOT_INIT: begin
          s_rem <= sq_sum[63:0];
          root  <= '0;
          sbit  <= 64'h4000_0000_0000_0000;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sbit == '0) begin
            len   <= len_next;
            j     <= '0;
            state <= (len_next == '0) ? S_FINISH : S_NORM_GO;
          end else begin
            if (root_fits) begin
              s_rem <= 64'(65'(s_rem) - root_try);
              root  <= (root >> 1) + sbit;
            end else begin
              root <= root >> 1;
            end
            sbit <= sbit >> 2;
          end
        end
        S_NORM_GO: begin
          state <= S_NORM_WAIT;
        end
        S_NORM_WAIT: begin
          if (div_done) begin
            r_vec[j] <= r_vec[j][31] ? -32'(div_quot) : 32'(div_quot);
            j        <= j + 1'b1;
            state    <= (j == 2'd3) ? S_FINISH : S_NORM_GO;
          end
        end
        S_FINISH: begin
          if (res_free) begin
            res_interior <= interior;
            res_used     <= used;
            for (int c = 0; c < 3; c++) begin
              res_c[c] <= r_vec[c];
            end
            res_c[3] <= (value_kind == KIND_QUAT) ? r_vec[3] : '0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result is never both interior and a fallback.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_interior && res_used))
    else $error("result flagged interior and fallback together");

  // Vector results carry a zero fourth component.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && value_kind == KIND_VECTOR) |-> (res_c[3] == '0))
    else $error("vector result with non-zero fourth component");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_FRAC || state == S_NORM_WAIT))
    else $error("divider finished outside a waiting state");

  // A new result is only loaded from the finishing state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == S_FINISH))
    else $error("result loaded outside the finishing state");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyframe track sampler. Key loads and samples
// are sent through the input channel with random idle bursts, results are
// taken with random stalls, and every result is compared field by field with
// a local model of the track table, the clamping, step, lerp and nlerp rules.
// ----------------------------------------------------------------------------
module testbench;
  import kts_pkg::*;

  localparam int  SLOTS     = 64;
  localparam int  SETTLE    = 220;
  localparam longint LIMIT  = 3000000;
  localparam logic [31:0] MIN_Q = 32'h8000_0000;
  localparam logic [31:0] MAX_Q = 32'h7fff_ffff;

  typedef struct packed {
    logic [31:0] c0, c1, c2, c3;
    logic        interior;
    logic        used_fallback;
  } sample_res_t;

  logic clk;
  logic rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  kts_in_if  in_ch ();
  kts_out_if out_ch ();

  keyframe_track_sampler_core dut (
    .clk      (clk),
    .rst      (rst),
    .item_in  (in_ch),
    .item_out (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Local copy of the configuration and the key table.
  logic        kind_q, mode_q;
  logic [6:0]  count_q;
  logic [31:0] fallback_q [4];
  logic [31:0] stamp_tab [SLOTS];
  longint      comp_tab [SLOTS][4];

  sample_res_t expected_samples[$];
  int          errors;
  longint      cycles;
  bit          quiet;      // no idling on either side
  int          stall_left;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Floor square root of a value of at most 2^64.
  function automatic logic [33:0] root_floor(input logic [65:0] s);
    logic [33:0] r;
    logic [67:0] sq;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      r[b] = 1'b1;
      sq = r * r;
      if (sq > s) r[b] = 1'b0;
    end
    return r;
  endfunction

  // Normalises a lerped quaternion; a zero quaternion is left as it is.
  function automatic void nlerp_normalise(inout longint q[4]);
    logic [65:0] s;
    logic [33:0] len;
    longint unsigned m;
    s = '0;
    for (int j = 0; j < 4; j++) begin
      m = (q[j] < 0) ? -q[j] : q[j];
      s += 66'(m) * 66'(m);
    end
    len = root_floor(s);
    if (len == 0) return;
    for (int j = 0; j < 4; j++) begin
      m = (q[j] < 0) ? -q[j] : q[j];
      m = (m << 16) / longint'(len);
      q[j] = (q[j] < 0) ? -longint'(m) : longint'(m);
    end
  endfunction

  // Works out the result of sampling the track at time t.
  function automatic sample_res_t track_value(input logic [31:0] t);
    sample_res_t e;
    longint r[4], b[4];
    int n, i0, i1;
    logic in_range;
    longint u;
    n = (count_q > SLOTS) ? SLOTS : count_q;
    in_range = 1'b0;
    u = 0;
    if (n == 0) begin
      for (int j = 0; j < 4; j++) r[j] = longint'($signed(fallback_q[j]));
    end else begin
      i0 = n - 1;
      i1 = n - 1;
      if (t <= stamp_tab[0]) begin
        i0 = 0;
        i1 = 0;
      end else if (t < stamp_tab[n-1]) begin
        for (int i = 0; i + 1 < n; i++) begin
          if (!in_range && t >= stamp_tab[i] && t < stamp_tab[i+1]) begin
            i0 = i;
            i1 = i + 1;
            u = (longint'(t - stamp_tab[i]) << 16) / longint'(stamp_tab[i+1] - stamp_tab[i]);
            in_range = 1'b1;
          end
        end
      end
      for (int j = 0; j < 4; j++) r[j] = comp_tab[i0][j];
      if (in_range && mode_q == MODE_LINEAR) begin
        for (int j = 0; j < 4; j++) begin
          b[j] = comp_tab[i1][j];
          r[j] = r[j] + (((b[j] - r[j]) * u) >>> 16);
        end
        if (kind_q == KIND_QUAT) nlerp_normalise(r);
      end
    end
    if (kind_q == KIND_VECTOR) r[3] = 0;
    e.c0 = r[0][31:0];
    e.c1 = r[1][31:0];
    e.c2 = r[2][31:0];
    e.c3 = r[3][31:0];
    e.interior = in_range;
    e.used_fallback = (n == 0);
    return e;
  endfunction

  // Appends the expected result of one sample item.
  function automatic void record_expected(input sample_res_t e);
    expected_samples = {expected_samples, e};
  endfunction

  // Result side: random stall bursts and the comparison of each result item.
  always @(posedge clk) begin
    sample_res_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result item c0=%h", $time, out_ch.out_c0);
          errors++;
        end else begin
          e = expected_samples.pop_front();
          if (e.c0 !== out_ch.out_c0) begin
            $display("%0t: out_c0 expected %h actual %h", $time, e.c0, out_ch.out_c0);
            errors++;
          end
          if (e.c1 !== out_ch.out_c1) begin
            $display("%0t: out_c1 expected %h actual %h", $time, e.c1, out_ch.out_c1);
            errors++;
          end
          if (e.c2 !== out_ch.out_c2) begin
            $display("%0t: out_c2 expected %h actual %h", $time, e.c2, out_ch.out_c2);
            errors++;
          end
          if (e.c3 !== out_ch.out_c3) begin
            $display("%0t: out_c3 expected %h actual %h", $time, e.c3, out_ch.out_c3);
            errors++;
          end
          if (e.interior !== out_ch.interior) begin
            $display("%0t: interior expected %b actual %b", $time, e.interior,
                     out_ch.interior);
            errors++;
          end
          if (e.used_fallback !== out_ch.used_fallback) begin
            $display("%0t: used_fallback expected %b actual %b", $time,
                     e.used_fallback, out_ch.used_fallback);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 4);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Sends one item, with an occasional idle burst first, and records what it
  // should produce once it has been accepted.
  task automatic send_item(input logic op, input logic [5:0] idx,
                           input logic [31:0] stamp, input logic [31:0] qt,
                           input logic [31:0] c0, input logic [31:0] c1,
                           input logic [31:0] c2, input logic [31:0] c3);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.key_index  <= idx;
    in_ch.key_stamp  <= stamp;
    in_ch.query_time <= qt;
    in_ch.in_c0      <= c0;
    in_ch.in_c1      <= c1;
    in_ch.in_c2      <= c2;
    in_ch.in_c3      <= c3;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_LOAD) begin
      stamp_tab[idx] = stamp;
      comp_tab[idx][0] = longint'($signed(c0));
      comp_tab[idx][1] = longint'($signed(c1));
      comp_tab[idx][2] = longint'($signed(c2));
      comp_tab[idx][3] = longint'($signed(c3));
    end else begin
      record_expected(track_value(qt));
    end
  endtask

  task automatic load_key(input int idx, input logic [31:0] stamp,
                          input logic [31:0] c0, input logic [31:0] c1,
                          input logic [31:0] c2, input logic [31:0] c3);
    send_item(OP_LOAD, idx[5:0], stamp, $urandom, c0, c1, c2, c3);
  endtask

  task automatic sample_at(input logic [31:0] t);
    send_item(OP_SAMPLE, 6'($urandom), $urandom, t, $urandom, $urandom, $urandom,
              $urandom);
  endtask

  // Stops sending and waits until every result is in and the block is idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes one configuration register while the block is idle.
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    in_ch.valid <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_VALUE_KIND:  kind_q = value[0];
      CFG_INTERP_MODE: mode_q = value[0];
      CFG_KEY_COUNT:   count_q = value[6:0];
      CFG_FALLBACK_C0: fallback_q[0] = value;
      CFG_FALLBACK_C1: fallback_q[1] = value;
      CFG_FALLBACK_C2: fallback_q[2] = value;
      default:         fallback_q[3] = value;
    endcase
  endtask

  function automatic logic [31:0] pick_comp();
    case ($urandom_range(0, 7))
      0:       return MIN_Q;
      1:       return MAX_Q;
      2:       return 32'd0;
      3, 4:    return 32'($signed($urandom_range(0, 262143)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  // Empty table: the fallback comes back, with w cleared for vectors.
  task automatic test_empty_table();
    sample_at(32'd0);
    sample_at(32'hffff_ffff);
    drain();
    write_reg(CFG_VALUE_KIND, KIND_QUAT);
    sample_at($urandom);
    drain();
    write_reg(CFG_FALLBACK_C0, MIN_Q);
    write_reg(CFG_FALLBACK_C1, MAX_Q);
    write_reg(CFG_FALLBACK_C2, 32'hffff_ffff);
    write_reg(CFG_FALLBACK_C3, MIN_Q);
    sample_at(32'h1234_5678);
    drain();
    write_reg(CFG_VALUE_KIND, KIND_VECTOR);
    sample_at(32'h0001_0000);
    drain();
  endtask

  // Fills every slot with a sorted track, then samples the edges, the keys
  // themselves and the inside in both modes and both kinds.
  task automatic test_directed_track();
    for (int k = 0; k < SLOTS; k++)
      load_key(k, 32'(k) << 20, (k % 2) ? MAX_Q : MIN_Q, 32'(k) << 16,
               32'(-k) <<< 12, 32'h0001_0000);
    write_reg(CFG_KEY_COUNT, 7'd64);
    sample_at(32'd0);
    sample_at(32'hffff_ffff);
    sample_at(32'h03f0_0000);
    sample_at(32'h0010_0000);
    sample_at(32'h0018_0000);
    sample_at(32'h03ef_ffff);
    drain();
    write_reg(CFG_INTERP_MODE, MODE_STEP);
    sample_at(32'h0018_0000);
    sample_at(32'h03f8_0000);
    drain();
    write_reg(CFG_VALUE_KIND, KIND_QUAT);
    sample_at(32'h0028_0000);
    drain();
    write_reg(CFG_INTERP_MODE, MODE_LINEAR);
    sample_at(32'h0028_0000);
    sample_at(32'h0020_0001);
    drain();
  endtask

  // Zero quaternion, the largest sum of squares, and an unsorted track.
  task automatic test_special_quaternions();
    load_key(0, 32'd100, 32'd0, 32'd0, 32'd0, 32'd0);
    load_key(1, 32'd200, 32'd0, 32'd0, 32'd0, 32'd0);
    load_key(2, 32'd300, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
    load_key(3, 32'd400, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
    drain();
    write_reg(CFG_KEY_COUNT, 7'd4);
    sample_at(32'd150);
    sample_at(32'd350);
    sample_at(32'd250);
    load_key(1, 32'd50, MAX_Q, 32'd1, 32'd2, 32'd3);
    sample_at(32'd120);
    sample_at(32'd399);
    drain();
    write_reg(CFG_KEY_COUNT, 7'd1);
    sample_at(32'd99);
    sample_at(32'd101);
    drain();
  endtask

  // Random tracks under random settings, with most samples inside the range.
  task automatic test_random_tracks(input int items);
    int sent, n;
    logic [31:0] base, stamp, lo, hi;
    sent = 0;
    while (sent < items) begin
      if (items - sent < 200) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0:       n = 0;
        1:       n = 1;
        2:       n = 64;
        3:       n = 2;
        default: n = $urandom_range(2, 16);
      endcase
      write_reg(CFG_VALUE_KIND, $urandom_range(0, 1));
      write_reg(CFG_INTERP_MODE, $urandom_range(0, 3) == 0);
      write_reg(CFG_KEY_COUNT, n);
      if ($urandom_range(0, 3) == 0)
        write_reg(cfg_idx_t'($urandom_range(3, 6)), pick_comp());
      base = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4096);
      stamp = base;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 19) == 0) stamp = $urandom;   // broken order
        load_key(k, stamp, pick_comp(), pick_comp(), pick_comp(), pick_comp());
        stamp = stamp + $urandom_range(0, 1 << $urandom_range(0, 24));
        sent++;
      end
      lo = stamp_tab[0];
      hi = (n > 0) ? stamp_tab[n-1] : 32'hffff_ffff;
      repeat ($urandom_range(8, 30)) begin
        case ($urandom_range(0, 9))
          0:       sample_at($urandom);
          1:       sample_at(stamp_tab[$urandom_range(0, (n > 0) ? n - 1 : 0)]);
          2:       load_key($urandom_range(0, 63), $urandom, pick_comp(), pick_comp(),
                            pick_comp(), pick_comp());
          default: sample_at((hi > lo) ?
                             lo + 32'(64'($urandom) % (64'(hi) - 64'(lo) + 64'd1)) : lo);
        endcase
        sent++;
      end
      drain();
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_VALUE_KIND;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD;
    in_ch.key_index = '0;
    in_ch.key_stamp = '0;
    in_ch.query_time = '0;
    in_ch.in_c0 = '0;
    in_ch.in_c1 = '0;
    in_ch.in_c2 = '0;
    in_ch.in_c3 = '0;
    kind_q = KIND_VECTOR;
    mode_q = MODE_LINEAR;
    count_q = '0;
    fallback_q[0] = '0;
    fallback_q[1] = '0;
    fallback_q[2] = '0;
    fallback_q[3] = 32'h0001_0000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_directed_track();
    test_special_quaternions();
    test_random_tracks(1950);

    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/kts_pkg.sv
rtl/core/kts_if.sv
rtl/core/kts_ram.sv
rtl/core/kts_lane.sv
rtl/core/kts_merge.sv
rtl/core/kts_div.sv
rtl/core/keyframe_track_sampler_core.sv
bench/testbench.sv
